[sv/flv_tag_header_parser_unit_macros.svh]
// assertion macros shared by the flv tag header parser modules
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef FLV_TAG_HEADER_PARSER_UNIT_MACROS_SVH
`define FLV_TAG_HEADER_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define FLVP_CHECK(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FLVP_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FLVP_CHECK(lbl, clk, rst_n, ante, cons, msg)
`define FLVP_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[sv/flvp_pkg.sv]
// shared types and constants of the flv tag header parser
// no dependencies
package flvp_pkg;

  localparam logic [3:0] FILE_HDR_LEN   = 4'd9;
  localparam logic [3:0] TAG_PREFIX_LEN = 4'd15;
  localparam logic [3:0] MEDIA_LEN      = 4'd2;
  localparam logic [3:0] CAPTURE_BYTES  = 4'd8;

  localparam logic [4:0] TAG_AUDIO = 5'd8;
  localparam logic [4:0] TAG_VIDEO = 5'd9;

  localparam logic [1:0] REC_FILE  = 2'd0;
  localparam logic [1:0] REC_TAG   = 2'd1;
  localparam logic [1:0] REC_VIDEO = 2'd2;
  localparam logic [1:0] REC_AUDIO = 2'd3;

  localparam int DATA_W = 136;
  localparam int USER_W = 2;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [31:0] size_word;
    logic [4:0]  tag_kind;
    logic        filter_flag;
    logic [23:0] payload_size;
    logic [23:0] time_low;
    logic [7:0]  time_ext;
    logic [23:0] stream_number;
    logic [3:0]  code_high;
    logic [3:0]  code_low;
    logic [1:0]  flag_bits;
    logic [7:0]  extra_byte;
  } rec_t;

endpackage

[sv/flvp_front.sv]
// front end: takes stream bytes, tracks the file/tag phase and builds records
// depends on flvp_pkg and the assertion macro header
`include "flv_tag_header_parser_unit_macros.svh"

module flvp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  output logic          push,
  output flvp_pkg::rec_t push_data
);
  import flvp_pkg::*;

  localparam logic [1:0] PH_FILE  = 2'd0;
  localparam logic [1:0] PH_TAG   = 2'd1;
  localparam logic [1:0] PH_MEDIA = 2'd2;
  localparam logic [1:0] PH_SKIP  = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] regs_r, regs_nxt;
  logic [55:0] more_r, more_nxt;
  logic [4:0]  kind_r, kind_nxt;
  logic [23:0] skip_r, skip_nxt;

  logic [3:0]  cnt_inc;
  logic [63:0] regs_new;
  logic [55:0] more_new;
  logic [23:0] skip_dec;
  logic [23:0] skip_media;
  logic [7:0]  tbyte;
  logic [7:0]  first_b;
  logic        emit;
  rec_t        rec;

  always_comb begin
    cnt_inc    = cnt_r + 4'd1;
    regs_new   = (cnt_r < CAPTURE_BYTES) ? {regs_r[55:0], in_byte} : regs_r;
    more_new   = (cnt_r < CAPTURE_BYTES) ? more_r : {more_r[47:0], in_byte};
    skip_dec   = (skip_r != 24'd0) ? skip_r - 24'd1 : 24'd0;
    skip_media = (skip_r >= 24'(MEDIA_LEN)) ? skip_r - 24'(MEDIA_LEN) : 24'd0;
    tbyte      = regs_new[31:24];
    first_b    = regs_new[15:8];

    phase_nxt = phase_r;
    cnt_nxt   = cnt_inc;
    regs_nxt  = regs_new;
    more_nxt  = more_new;
    kind_nxt  = kind_r;
    skip_nxt  = skip_r;
    emit      = 1'b0;
    rec       = '0;

    unique case (phase_r)
      PH_FILE: begin
        if (cnt_inc == FILE_HDR_LEN) begin
          emit            = 1'b1;
          rec.record_kind = REC_FILE;
          rec.size_word   = {regs_new[23:0], more_new[7:0]};
          rec.flag_bits   = {regs_new[26], regs_new[24]};
          rec.extra_byte  = regs_new[39:32];
          cnt_nxt         = 4'd0;
          phase_nxt       = PH_TAG;
        end
      end
      PH_TAG: begin
        if (cnt_inc == TAG_PREFIX_LEN) begin
          emit              = 1'b1;
          rec.record_kind   = REC_TAG;
          rec.size_word     = regs_new[63:32];
          rec.tag_kind      = tbyte[4:0];
          rec.filter_flag   = tbyte[5];
          rec.payload_size  = regs_new[23:0];
          rec.time_low      = more_new[55:32];
          rec.time_ext      = more_new[31:24];
          rec.stream_number = more_new[23:0];
          kind_nxt          = tbyte[4:0];
          skip_nxt          = regs_new[23:0];
          cnt_nxt           = 4'd0;
          if (tbyte[4:0] == TAG_AUDIO || tbyte[4:0] == TAG_VIDEO) begin
            phase_nxt = PH_MEDIA;
          end else begin
            phase_nxt = (regs_new[23:0] == 24'd0) ? PH_TAG : PH_SKIP;
          end
        end
      end
      PH_MEDIA: begin
        if (cnt_inc == MEDIA_LEN) begin
          emit           = 1'b1;
          rec.tag_kind   = kind_r;
          rec.code_high  = first_b[7:4];
          rec.extra_byte = regs_new[7:0];
          if (kind_r == TAG_VIDEO) begin
            rec.record_kind = REC_VIDEO;
            rec.code_low    = first_b[3:0];
          end else begin
            rec.record_kind = REC_AUDIO;
            rec.code_low    = {2'b00, first_b[3:2]};
            rec.flag_bits   = first_b[1:0];
          end
          skip_nxt  = skip_media;
          cnt_nxt   = 4'd0;
          phase_nxt = (skip_media == 24'd0) ? PH_TAG : PH_SKIP;
        end
      end
      PH_SKIP: begin
        // skipped payload bytes leave the capture registers alone
        regs_nxt = regs_r;
        more_nxt = more_r;
        cnt_nxt  = cnt_r;
        skip_nxt = skip_dec;
        if (skip_dec == 24'd0) begin
          cnt_nxt   = 4'd0;
          phase_nxt = PH_TAG;
        end
      end
      default: begin
        phase_nxt = PH_FILE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FILE;
      cnt_r   <= 4'd0;
      kind_r  <= 5'd0;
      skip_r  <= 24'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      kind_r  <= kind_nxt;
      skip_r  <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      regs_r <= regs_nxt;
      more_r <= more_nxt;
    end
  end

  assign push      = accept && emit;
  assign push_data = rec;

  `FLVP_CHECK(a_skip_nonzero, clk, rst_n, phase_r == PH_SKIP, skip_r != 24'd0,
              "skip phase with nothing left to skip")
  `FLVP_CHECK(a_media_kind, clk, rst_n, phase_r == PH_MEDIA,
              kind_r == TAG_AUDIO || kind_r == TAG_VIDEO, "media phase on a non-media tag")
  `FLVP_CHECK_NEXT(a_media_done, clk, rst_n,
                   accept && phase_r == PH_MEDIA && cnt_r == 4'd1,
                   phase_r == PH_TAG || phase_r == PH_SKIP,
                   "media phase did not end after its second byte")

endmodule

[sv/flvp_queue.sv]
// short record queue between the parser front end and the output stage
// depends on flvp_pkg and the assertion macro header
`include "flv_tag_header_parser_unit_macros.svh"

module flvp_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  flvp_pkg::rec_t push_data,
  output logic           full,
  input  logic           pop,
  output flvp_pkg::rec_t pop_data,
  output logic           not_empty
);
  import flvp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  assign pop_data  = entry_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == CW'(DEPTH));

  `FLVP_CHECK(a_no_overflow, clk, rst_n, push, !full || pop, "push into a full queue")
  `FLVP_CHECK(a_no_underflow, clk, rst_n, pop, not_empty, "pop from an empty queue")
  `FLVP_CHECK_NEXT(a_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1,
                   "queue count lost a push")

endmodule

[sv/flvp_back.sv]
// back end: output register that packs records onto the result stream
// depends on flvp_pkg
module flvp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_not_empty,
  input  flvp_pkg::rec_t              q_data,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [flvp_pkg::DATA_W-1:0] out_tdata,
  output logic [flvp_pkg::USER_W-1:0] out_tuser
);
  import flvp_pkg::*;

  logic              valid_r;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [USER_W-1:0] user_r;
  logic              load;

  assign load  = q_not_empty && (!valid_r || out_tready);
  assign q_pop = load;

  // first field in the lowest bits
  assign data_nxt = {q_data.extra_byte, q_data.flag_bits, q_data.code_low, q_data.code_high,
                     q_data.stream_number, q_data.time_ext, q_data.time_low,
                     q_data.payload_size, q_data.filter_flag, q_data.tag_kind,
                     q_data.size_word};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      user_r <= q_data.record_kind;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

[sv/flv_tag_header_parser_unit.sv]
// Byte-serial FLV container parser: file header, tag headers, media info bytes.
// Input stream in_*: one stream byte per transfer in in_tdata.
// Result stream out_*: one record per transfer; out_tuser gives the record kind
// (0 file header, 1 tag header, 2 video info, 3 audio info), out_tdata the fields.
// A record comes out on the byte that completes it: the ninth header byte, the
// fifteenth byte of each tag prefix and the second media payload byte. Payload
// bytes after that are consumed without producing a transfer.
// Throughput: one byte per cycle while in_tready is high. A finished record is written
// into the queue and moves on to the output register when that register is free.
// The front end and the output register are joined by a QUEUE_DEPTH-entry queue;
// in_tready drops only while that queue is full, so a stalled receiver holds the
// current record stable and the input keeps flowing until the queue fills.
// Reset (rst_n low, synchronous) returns to the file header phase and empties
// the queue and the output register.
// depends on flvp_pkg, flvp_front, flvp_queue, flvp_back
module flv_tag_header_parser_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] in_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [31:0] size_word, [36:32] tag_kind, [37] filter_flag, [61:38] payload_size,
  // [85:62] time_low, [93:86] time_ext, [117:94] stream_number, [121:118] code_high,
  // [125:122] code_low, [127:126] flag_bits, [135:128] extra_byte
  output logic [flvp_pkg::DATA_W-1:0] out_tdata,
  output logic [flvp_pkg::USER_W-1:0] out_tuser   // [1:0] record_kind
);
  import flvp_pkg::*;

  logic accept;
  logic push;
  rec_t push_data;
  logic q_full;
  logic q_pop;
  rec_t q_data;
  logic q_not_empty;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  flvp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_tdata),
    .push      (push),
    .push_data (push_data)
  );

  flvp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_not_empty)
  );

  flvp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

[dv/flv_parse_checker.sv]
// checker for the flv tag header parser: watches both streams, predicts records from the
// accepted bytes and compares every result transfer field by field
// depends on flvp_pkg
`timescale 1ns / 1ps

module flv_parse_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [7:0]                  in_tdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [flvp_pkg::DATA_W-1:0] out_tdata,
  input  logic [flvp_pkg::USER_W-1:0] out_tuser,
  output int                          fail_count,
  output int                          pending_count
);
  import flvp_pkg::*;

  typedef enum logic [1:0] {
    PARSE_FILE,
    PARSE_PREFIX,
    PARSE_MEDIA,
    PARSE_SKIP
  } parse_phase_t;

  parse_phase_t parse_phase = PARSE_FILE;
  logic [3:0]   bytes_in_phase = '0;
  logic [63:0]  head_bytes = '0;
  logic [55:0]  tail_bytes = '0;
  logic [4:0]   cur_kind = '0;
  logic [23:0]  skip_left = '0;
  rec_t         expected_records[$];

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  task automatic note_failure(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      note_failure($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task automatic clear_capture();
    bytes_in_phase = '0;
    head_bytes = '0;
    tail_bytes = '0;
  endtask

  task automatic finish_payload();
    clear_capture();
    parse_phase = (skip_left == 0) ? PARSE_PREFIX : PARSE_SKIP;
  endtask

  // advance the parser by one stream byte, queueing the record it completes
  task automatic parse_byte(input logic [7:0] b);
    rec_t       rec;
    logic [7:0] type_byte;
    logic [7:0] info0;
    logic [7:0] info1;
    rec = '0;
    if (parse_phase == PARSE_SKIP) begin
      if (skip_left != 0) skip_left--;
      if (skip_left == 0) begin
        clear_capture();
        parse_phase = PARSE_PREFIX;
      end
      return;
    end
    if (bytes_in_phase < CAPTURE_BYTES) head_bytes = {head_bytes[55:0], b};
    else tail_bytes = {tail_bytes[47:0], b};
    bytes_in_phase = bytes_in_phase + 4'd1;
    case (parse_phase)
      PARSE_FILE: begin
        if (bytes_in_phase != FILE_HDR_LEN) return;
        rec.record_kind = REC_FILE;
        rec.size_word   = {head_bytes[23:0], tail_bytes[7:0]};
        rec.flag_bits   = {head_bytes[26], head_bytes[24]};
        rec.extra_byte  = head_bytes[39:32];
        clear_capture();
        parse_phase = PARSE_PREFIX;
      end
      PARSE_PREFIX: begin
        if (bytes_in_phase != TAG_PREFIX_LEN) return;
        type_byte = head_bytes[31:24];
        rec.record_kind   = REC_TAG;
        rec.size_word     = head_bytes[63:32];
        rec.tag_kind      = type_byte[4:0];
        rec.filter_flag   = type_byte[5];
        rec.payload_size  = head_bytes[23:0];
        rec.time_low      = tail_bytes[55:32];
        rec.time_ext      = tail_bytes[31:24];
        rec.stream_number = tail_bytes[23:0];
        cur_kind  = type_byte[4:0];
        skip_left = head_bytes[23:0];
        if (cur_kind == TAG_AUDIO || cur_kind == TAG_VIDEO) begin
          clear_capture();
          parse_phase = PARSE_MEDIA;
        end else begin
          finish_payload();
        end
      end
      default: begin
        if (bytes_in_phase != MEDIA_LEN) return;
        info0 = head_bytes[15:8];
        info1 = head_bytes[7:0];
        rec.tag_kind   = cur_kind;
        rec.code_high  = info0[7:4];
        rec.extra_byte = info1;
        if (cur_kind == TAG_VIDEO) begin
          rec.record_kind = REC_VIDEO;
          rec.code_low    = info0[3:0];
        end else begin
          rec.record_kind = REC_AUDIO;
          rec.code_low    = {2'b00, info0[3:2]};
          rec.flag_bits   = info0[1:0];
        end
        skip_left = (skip_left >= 24'd2) ? skip_left - 24'd2 : 24'd0;
        finish_payload();
      end
    endcase
    expected_records.push_back(rec);
  endtask

  always @(posedge clk) begin
    rec_t got;
    rec_t want;
    if (!rst_n) begin
      parse_phase = PARSE_FILE;
      clear_capture();
      cur_kind = '0;
      skip_left = '0;
      expected_records.delete();
    end else begin
      if (in_tvalid && in_tready) parse_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_records.size() == 0) begin
          note_failure($sformatf("record transfer (kind %0d) with nothing expected", out_tuser));
        end else begin
          want = expected_records.pop_front();
          got.record_kind   = out_tuser[1:0];
          got.size_word     = out_tdata[31:0];
          got.tag_kind      = out_tdata[36:32];
          got.filter_flag   = out_tdata[37];
          got.payload_size  = out_tdata[61:38];
          got.time_low      = out_tdata[85:62];
          got.time_ext      = out_tdata[93:86];
          got.stream_number = out_tdata[117:94];
          got.code_high     = out_tdata[121:118];
          got.code_low      = out_tdata[125:122];
          got.flag_bits     = out_tdata[127:126];
          got.extra_byte    = out_tdata[135:128];
          check_field("record_kind", 32'(got.record_kind), 32'(want.record_kind));
          check_field("size_word", got.size_word, want.size_word);
          check_field("tag_kind", 32'(got.tag_kind), 32'(want.tag_kind));
          check_field("filter_flag", 32'(got.filter_flag), 32'(want.filter_flag));
          check_field("payload_size", 32'(got.payload_size), 32'(want.payload_size));
          check_field("time_low", 32'(got.time_low), 32'(want.time_low));
          check_field("time_ext", 32'(got.time_ext), 32'(want.time_ext));
          check_field("stream_number", 32'(got.stream_number), 32'(want.stream_number));
          check_field("code_high", 32'(got.code_high), 32'(want.code_high));
          check_field("code_low", 32'(got.code_low), 32'(want.code_low));
          check_field("flag_bits", 32'(got.flag_bits), 32'(want.flag_bits));
          check_field("extra_byte", 32'(got.extra_byte), 32'(want.extra_byte));
        end
      end
    end
    pending_count <= expected_records.size();
  end

endmodule

[dv/testbench.sv]
// top of the flv tag header parser testbench: builds an flv byte stream, drives it with
// random gaps and receiver stalls, and gives the verdict from flv_parse_checker
// depends on flvp_pkg, flv_tag_header_parser_unit, flv_parse_checker
`timescale 1ns / 1ps

module testbench;
  import flvp_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_BYTES = 200;
  localparam int NO_CAP       = 1 << 30;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [DATA_W-1:0]   out_tdata;
  logic [USER_W-1:0]   out_tuser;
  int                  fail_count;
  int                  pending_count;
  int                  load_phase = 0;
  int                  stall_cycles = 0;
  logic [7:0]          flv_stream[$];

  always #4 clk = ~clk;

  flv_tag_header_parser_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  flv_parse_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  task automatic push_be(input logic [31:0] value, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) flv_stream.push_back(value[8*i +: 8]);
  endtask

  // previous tag size, 11-byte tag header, media info bytes, then payload filler
  task automatic add_tag(input logic [31:0] prev_size, input logic [7:0] type_byte,
                         input logic [23:0] payload_len, input logic [23:0] stamp,
                         input logic [7:0] stamp_ext, input logic [23:0] stream_id,
                         input logic [7:0] info0, input logic [7:0] info1,
                         input int fill_cap);
    int rest;
    push_be(prev_size, 4);
    flv_stream.push_back(type_byte);
    push_be({8'h00, payload_len}, 3);
    push_be({8'h00, stamp}, 3);
    flv_stream.push_back(stamp_ext);
    push_be({8'h00, stream_id}, 3);
    rest = int'(payload_len);
    if (type_byte[4:0] == TAG_AUDIO || type_byte[4:0] == TAG_VIDEO) begin
      flv_stream.push_back(info0);
      flv_stream.push_back(info1);
      rest = (rest >= 2) ? rest - 2 : 0;
    end
    for (int i = 0; i < rest && i < fill_cap; i++) begin
      flv_stream.push_back(8'($urandom_range(255)));
    end
  endtask

  // stream source: file header, directed tags, random tags, one huge tag left unfinished
  initial begin
    int         directed_len;
    int         idx;
    int         total;
    int         mode;
    int         gap_pct;
    bit         took;
    logic [7:0] tb;
    logic [23:0] dsize;
    for (int i = 0; i < 9; i++) flv_stream.push_back(8'($urandom_range(255)));
    add_tag(32'h0, 8'h08, 24'd2, 24'h0, 8'h00, 24'h0, 8'h00, 8'h00, NO_CAP);
    add_tag(32'hFFFF_FFFF, 8'hE9, 24'd5, 24'hFF_FFFF, 8'hFF, 24'hFF_FFFF, 8'hFF, 8'hFF,
            NO_CAP);
    // media tags shorter than their two info bytes
    add_tag(32'h1234_5678, 8'h28, 24'd0, 24'h00_0100, 8'h01, 24'h0, 8'hAF, 8'h01, NO_CAP);
    add_tag(32'h0000_0010, 8'h09, 24'd1, 24'h80_0000, 8'h80, 24'h1, 8'h17, 8'h00, NO_CAP);
    // non-media tags: empty payload, short skip, type 31 with reserved bits but no filter, type 0; then an audio tag
    add_tag(32'hA5A5_5A5A, 8'h12, 24'd0, 24'h12_3456, 8'h7F, 24'h0, 8'h00, 8'h00, NO_CAP);
    add_tag(32'h0000_001B, 8'h12, 24'd3, 24'h00_0001, 8'h00, 24'h80_0000, 8'h00, 8'h00,
            NO_CAP);
    add_tag(32'h8000_0000, 8'hDF, 24'd4, 24'h7F_FFFF, 8'h55, 24'h0, 8'h00, 8'h00, NO_CAP);
    add_tag(32'h0000_0001, 8'h00, 24'd1, 24'h0, 8'hAA, 24'h0, 8'h00, 8'h00, NO_CAP);
    add_tag(32'h0000_0013, 8'h08, 24'd7, 24'h00_0FFF, 8'h00, 24'h0, 8'h5E, 8'h80, NO_CAP);
    directed_len = flv_stream.size();
    while (flv_stream.size() < directed_len + RANDOM_BYTES) begin
      tb = 8'($urandom_range(255));
      case ($urandom_range(9))
        0, 1, 2, 3: tb[4:0] = TAG_AUDIO;
        4, 5, 6, 7: tb[4:0] = TAG_VIDEO;
        default: ;
      endcase
      if ($urandom_range(1) == 0) tb[7:5] = 3'b000;
      dsize = ($urandom_range(7) == 0) ? 24'($urandom_range(64)) : 24'($urandom_range(10));
      add_tag($urandom, tb, dsize, 24'($urandom_range(24'hFF_FFFF)),
              8'($urandom_range(255)),
              ($urandom_range(3) == 0) ? 24'($urandom_range(24'hFF_FFFF)) : 24'h0,
              8'($urandom_range(255)), 8'($urandom_range(255)), NO_CAP);
    end
    // largest data size; the stream ends inside its payload
    add_tag($urandom, 8'hFF, 24'hFF_FFFF, 24'($urandom_range(24'hFF_FFFF)),
            8'($urandom_range(255)), 24'($urandom_range(24'hFF_FFFF)), 8'h00, 8'h00, 16);
    total = flv_stream.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    idx = 0;
    while (idx < total) begin
      @(posedge clk);
      took = in_tvalid && in_tready;
      if (took) idx++;
      mode = (idx * 3) / total;
      load_phase <= mode;
      gap_pct = (mode == 0) ? 20 : (mode == 1) ? 87 : 0;
      if (idx == total) begin
        in_tvalid <= 1'b0;
      end else if (!in_tvalid || took) begin
        if ($urandom_range(99) < gap_pct) begin
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata  <= flv_stream[idx];
        end
      end
    end

    do @(posedge clk); while (pending_count != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // record sink: heavy stalls, then light, then one long hold-off so the input backs up
  initial begin
    bit held;
    int stall_pct;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (load_phase == 2 && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall_pct = (load_phase == 0) ? 87 : (load_phase == 1) ? 20 : 0;
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // cycles without any transfer on either stream
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

[files.f]
+incdir+sv
sv/flvp_pkg.sv
sv/flvp_front.sv
sv/flvp_queue.sv
sv/flvp_back.sv
sv/flv_tag_header_parser_unit.sv
dv/flv_parse_checker.sv
dv/testbench.sv
